// ===== design/tmdm_pkg.sv =====
// shared types, constants and helper function of the delay mirror
`timescale 1ns / 1ps

package tmdm_pkg;

    localparam int STAMP_W     = 32;
    localparam int JOINT_W     = 16;
    localparam int QUAT_W      = 4 * JOINT_W;
    localparam int SLOT_OUT_W  = 9;
    localparam int MODE_W      = 2;
    localparam int DELAY_W     = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_LEFT;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_MS    = 1'd1;

    typedef logic signed [JOINT_W-1:0] joint_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp_ms;
        joint_t             upper_w;
        joint_t             upper_x;
        joint_t             upper_y;
        joint_t             upper_z;
        joint_t             fore_w;
        joint_t             fore_x;
        joint_t             fore_y;
        joint_t             fore_z;
    } in_word_t;

    typedef struct packed {
        logic                  mirrored;
        joint_t                out_upper_w;
        joint_t                out_upper_x;
        joint_t                out_upper_y;
        joint_t                out_upper_z;
        joint_t                out_fore_w;
        joint_t                out_fore_x;
        joint_t                out_fore_y;
        joint_t                out_fore_z;
        logic [SLOT_OUT_W-1:0] chosen_slot;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic               start;
        logic [STAMP_W-1:0] ideal;
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic live;
    } scan_rsp_t;

    function automatic joint_t neg_sat(input joint_t v);
        joint_t r;
        if (v == joint_t'(16'sh8000))
        begin
            r = joint_t'(16'sh7fff);
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

endpackage

// ===== design/tmdm_if.sv =====
// valid/ready channel interfaces for frames and results
`timescale 1ns / 1ps

interface tmdm_in_if;
    import tmdm_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmdm_out_if;
    import tmdm_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/tmdm_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tmdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tmdm_scan.sv =====
// nearest-timestamp search over the history, one slot per cycle
`timescale 1ns / 1ps

module tmdm_scan #(
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmdm_pkg::scan_req_t          req,
    input  logic [AW-1:0]                fill_slot,
    input  logic                         full,
    output logic [AW-1:0]                rd_addr,
    input  logic [tmdm_pkg::STAMP_W-1:0] rd_data,
    output tmdm_pkg::scan_rsp_t          rsp,
    output logic [AW-1:0]                best_idx
);
    import tmdm_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic               issue_reg;
    logic [AW-1:0]      addr_reg;
    logic [STAMP_W-1:0] ideal_reg;
    logic               p1_valid_reg;
    logic [AW-1:0]      p1_idx_reg;
    logic               p1_live_reg;
    logic               p2_valid_reg;
    logic [AW-1:0]      p2_idx_reg;
    logic               p2_live_reg;
    logic [STAMP_W-1:0] p2_dist_reg;
    logic [STAMP_W-1:0] best_dist_reg;
    logic [AW-1:0]      best_idx_reg;
    logic               best_live_reg;
    logic               done_reg;

    logic [STAMP_W-1:0] stored;
    logic [STAMP_W-1:0] dist_next;
    logic               take;

    // slots never written read as zero
    always_comb
    begin
        stored    = p1_live_reg ? rd_data : '0;
        dist_next = (ideal_reg >= stored) ? (ideal_reg - stored) : (stored - ideal_reg);
        take      = p2_valid_reg && (p2_dist_reg <= best_dist_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && (addr_reg == LAST))
            begin
                issue_reg <= 1'b0;
            end
            p1_valid_reg <= issue_reg;
            p2_valid_reg <= p1_valid_reg;
            done_reg     <= p2_valid_reg && (p2_idx_reg == LAST);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            addr_reg      <= '0;
            ideal_reg     <= req.ideal;
            best_dist_reg <= '1;
        end
        else
        begin
            if (issue_reg)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (take)
            begin
                best_dist_reg <= p2_dist_reg;
            end
        end
        p1_idx_reg  <= addr_reg;
        p1_live_reg <= full || (addr_reg < fill_slot);
        p2_idx_reg  <= p1_idx_reg;
        p2_live_reg <= p1_live_reg;
        p2_dist_reg <= dist_next;
        // ascending order with <= leaves the highest slot among ties
        if (take)
        begin
            best_idx_reg  <= p2_idx_reg;
            best_live_reg <= p2_live_reg;
        end
    end

    assign rd_addr  = addr_reg;
    assign best_idx = best_idx_reg;
    assign rsp.done = done_reg;
    assign rsp.live = best_live_reg;

endmodule

// ===== design/timestamp_matched_delay_mirror.sv =====
// top level of the timestamp-matched delay mirror
`timescale 1ns / 1ps

// Each frame word on the frame channel carries a millisecond stamp and the
// upper arm and forearm quaternions of the source arm. The frame is stored
// in a history ring of HISTORY_DEPTH slots; one result word per frame leaves
// on the result channel. A word is moved when valid and ready are both high.
// When delay_ms is nonzero and the stamp exceeds it, every slot is compared,
// one slot per cycle through a single subtract-and-compare unit, against
// stamp minus delay; the nearest stored stamp wins, the highest slot on a
// tie. In mirror modes the chosen slot's joints leave with y and z negated
// (saturating); modes 0 and 3 pass the current joints.
// An accepted frame is written to the history, scanned when the search
// applies, and its chosen joints are fetched and loaded as the result.
// One frame is in work at a time; frame ready is high only between frames,
// so no frame is taken before the last one is loaded. The result is held in an
// output register; a stalled receiver holds the block in its final step until
// the word leaves. Reset empties the history, which then reads as zero stamps
// and joints (tracked by a fill pointer, no clearing pass), sets mirror_mode
// to 1 and delay_ms to 0. Configuration is written through cfg_we/cfg_index/cfg_data.
module timestamp_matched_delay_mirror #(
    parameter int HISTORY_DEPTH = 512
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tmdm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tmdm_pkg::CFG_DATA_W-1:0]  cfg_data,
    tmdm_in_if.sink                          frame,
    tmdm_out_if.source                       result
);
    import tmdm_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [AW-1:0]       wslot_reg;
    logic                full_reg;
    in_word_t            in_reg;
    logic [AW-1:0]       cur_reg;
    logic [AW-1:0]       chosen_reg;
    logic [AW-1:0]       chosen_next;
    logic                live_reg;
    logic                live_next;
    logic                out_valid_reg;
    out_word_t           out_data_reg;
    out_word_t           out_next;

    logic                accept;
    logic                ram_we;
    logic                search;
    logic                load;
    logic                mirror;
    scan_req_t           scan_req;
    scan_rsp_t           scan_rsp;
    logic [AW-1:0]       scan_addr;
    logic [AW-1:0]       scan_best;
    logic [STAMP_W-1:0]  stamp_rd;
    logic [2*QUAT_W-1:0] joint_wr;
    logic [2*QUAT_W-1:0] joint_rd;
    logic [2*QUAT_W-1:0] joint_sel;

    assign accept = frame.valid && frame.ready;
    assign mirror = (mode_reg == MODE_LEFT) || (mode_reg == MODE_RIGHT);
    assign search = (delay_reg != '0) && (in_reg.stamp_ms > STAMP_W'(delay_reg));

    // w in the low lane, forearm above upper arm
    assign joint_wr = {in_reg.fore_z, in_reg.fore_y, in_reg.fore_x, in_reg.fore_w,
                       in_reg.upper_z, in_reg.upper_y, in_reg.upper_x, in_reg.upper_w};
    assign joint_sel = live_reg ? joint_rd : '0;

    tmdm_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (in_reg.stamp_ms),
        .raddr (scan_addr),
        .rdata (stamp_rd)
    );

    tmdm_ram #(
        .WIDTH (2 * QUAT_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_joint_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (joint_wr),
        .raddr (chosen_reg),
        .rdata (joint_rd)
    );

    tmdm_scan #(
        .DEPTH (HISTORY_DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (scan_req),
        .fill_slot (wslot_reg),
        .full      (full_reg),
        .rd_addr   (scan_addr),
        .rd_data   (stamp_rd),
        .rsp       (scan_rsp),
        .best_idx  (scan_best)
    );

    always_comb
    begin
        state_next     = state_reg;
        frame.ready    = 1'b0;
        ram_we         = 1'b0;
        scan_req.start = 1'b0;
        scan_req.ideal = in_reg.stamp_ms - STAMP_W'(delay_reg);
        chosen_next    = chosen_reg;
        live_next      = live_reg;
        load           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                frame.ready = 1'b1;
                if (frame.valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
                if (search)
                begin
                    scan_req.start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    chosen_next = cur_reg;
                    live_next   = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    chosen_next = scan_best;
                    live_next   = scan_rsp.live;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (mirror)
        begin
            out_next.mirrored    = 1'b1;
            out_next.out_upper_w = joint_t'(joint_sel[15:0]);
            out_next.out_upper_x = joint_t'(joint_sel[31:16]);
            out_next.out_upper_y = neg_sat(joint_t'(joint_sel[47:32]));
            out_next.out_upper_z = neg_sat(joint_t'(joint_sel[63:48]));
            out_next.out_fore_w  = joint_t'(joint_sel[79:64]);
            out_next.out_fore_x  = joint_t'(joint_sel[95:80]);
            out_next.out_fore_y  = neg_sat(joint_t'(joint_sel[111:96]));
            out_next.out_fore_z  = neg_sat(joint_t'(joint_sel[127:112]));
            out_next.chosen_slot = SLOT_OUT_W'(chosen_reg);
        end
        else
        begin
            out_next.mirrored    = 1'b0;
            out_next.out_upper_w = in_reg.upper_w;
            out_next.out_upper_x = in_reg.upper_x;
            out_next.out_upper_y = in_reg.upper_y;
            out_next.out_upper_z = in_reg.upper_z;
            out_next.out_fore_w  = in_reg.fore_w;
            out_next.out_fore_x  = in_reg.fore_x;
            out_next.out_fore_y  = in_reg.fore_y;
            out_next.out_fore_z  = in_reg.fore_z;
            out_next.chosen_slot = SLOT_OUT_W'(cur_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_RESET;
            delay_reg     <= '0;
            wslot_reg     <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIRROR_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                    CFG_DELAY_MS:    delay_reg <= cfg_data[DELAY_W-1:0];
                    default:         mode_reg  <= mode_reg;
                endcase
            end
            if (ram_we)
            begin
                if (wslot_reg == LAST)
                begin
                    wslot_reg <= '0;
                    full_reg  <= 1'b1;
                end
                else
                begin
                    wslot_reg <= wslot_reg + AW'(1);
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg  <= frame.data;
            cur_reg <= wslot_reg;
        end
        chosen_reg <= chosen_next;
        live_reg   <= live_next;
        if (load)
        begin
            out_data_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule
